/* rtl/assert_macros.svh */
// Assertion macros used by the RTL top of the control decode block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

/* rtl/rv32cd_pkg.sv */
// Types, codes and helper functions of the RV32I control decode block.
package rv32cd_pkg;

   // Major opcodes
   localparam logic [6:0] OPC_REG    = 7'h33;
   localparam logic [6:0] OPC_IMM    = 7'h13;
   localparam logic [6:0] OPC_LOAD   = 7'h03;
   localparam logic [6:0] OPC_STORE  = 7'h23;
   localparam logic [6:0] OPC_BRANCH = 7'h63;
   localparam logic [6:0] OPC_JAL    = 7'h6F;
   localparam logic [6:0] OPC_JALR   = 7'h67;
   localparam logic [6:0] OPC_LUI    = 7'h37;
   localparam logic [6:0] OPC_AUIPC  = 7'h17;
   localparam logic [6:0] OPC_SYSTEM = 7'h73;

   // Commands
   localparam logic CMD_DECODE = 1'b0;
   localparam logic CMD_BRANCH = 1'b1;

   // ALU operations
   localparam logic [3:0] ALU_ADD  = 4'd0;
   localparam logic [3:0] ALU_SUB  = 4'd1;
   localparam logic [3:0] ALU_SLL  = 4'd2;
   localparam logic [3:0] ALU_SLT  = 4'd3;
   localparam logic [3:0] ALU_SLTU = 4'd4;
   localparam logic [3:0] ALU_XOR  = 4'd5;
   localparam logic [3:0] ALU_SRL  = 4'd6;
   localparam logic [3:0] ALU_SRA  = 4'd7;
   localparam logic [3:0] ALU_OR   = 4'd8;
   localparam logic [3:0] ALU_AND  = 4'd9;

   // Next-pc sources
   localparam logic [1:0] PC_SEQ  = 2'd0;
   localparam logic [1:0] PC_JUMP = 2'd1;
   localparam logic [1:0] PC_REG  = 2'd2;

   // Writeback sources
   localparam logic [1:0] WB_ALU = 2'd0;
   localparam logic [1:0] WB_MEM = 2'd1;
   localparam logic [1:0] WB_RET = 2'd2;

   // Operand selects
   localparam logic SEL_A_REG = 1'b0;
   localparam logic SEL_A_PC  = 1'b1;
   localparam logic SEL_B_REG = 1'b0;
   localparam logic SEL_B_IMM = 1'b1;

   // funct3 codes with a special meaning
   localparam logic [2:0] F3_ADD_SUB = 3'd0;
   localparam logic [2:0] F3_SHR     = 3'd5;

   // Input word of the request channel
   typedef struct packed {
      logic       command;
      logic [6:0] opcode;
      logic [2:0] funct3;
      logic [6:0] funct7;
      logic [6:0] imm_upper;
      logic [4:0] src1_index;
      logic [4:0] src2_index;
      logic [4:0] dest_index;
      logic       is_branch;
      logic       cmp_equal;
      logic       cmp_less;
      logic       cmp_less_unsigned;
   } req_word_type;

   // Pipeline control word kept between commands
   typedef struct packed {
      logic [1:0] pc_select;
      logic [4:0] src_a_reg;
      logic [4:0] src_b_reg;
      logic       alu_a_sel;
      logic       alu_b_sel;
      logic [3:0] alu_op;
      logic       mem_write;
      logic [1:0] mem_data_sel;
      logic [2:0] mem_format;
      logic       reg_write;
      logic [4:0] write_reg;
   } ctrl_word_type;

   // Bits of the control word below pc_select
   localparam int unsigned CTRL_LOW_BITS = $bits(ctrl_word_type) - 2;

   // ALU op from funct3, with the alternate (sub / arithmetic shift) encoding
   function automatic logic [3:0] alu_op_for(input logic [2:0] f3, input logic alt);
      logic [3:0] op;
      case (f3)
         3'd0:    op = alt ? ALU_SUB : ALU_ADD;
         3'd1:    op = ALU_SLL;
         3'd2:    op = ALU_SLT;
         3'd3:    op = ALU_SLTU;
         3'd4:    op = ALU_XOR;
         3'd5:    op = alt ? ALU_SRA : ALU_SRL;
         3'd6:    op = ALU_OR;
         default: op = ALU_AND;
      endcase
      return op;
   endfunction

endpackage

/* rtl/rv32cd_channels.sv */
// Valid/ready channel interfaces for request and response words.
interface rv32cd_req_if;
   logic       valid;
   logic       ready;
   logic       command;
   logic [6:0] opcode;
   logic [2:0] funct3;
   logic [6:0] funct7;
   logic [6:0] imm_upper;
   logic [4:0] src1_index;
   logic [4:0] src2_index;
   logic [4:0] dest_index;
   logic       is_branch;
   logic       cmp_equal;
   logic       cmp_less;
   logic       cmp_less_unsigned;

   modport source (
      output valid, command, opcode, funct3, funct7, imm_upper, src1_index,
             src2_index, dest_index, is_branch, cmp_equal, cmp_less, cmp_less_unsigned,
      input  ready
   );
   modport sink (
      input  valid, command, opcode, funct3, funct7, imm_upper, src1_index,
             src2_index, dest_index, is_branch, cmp_equal, cmp_less, cmp_less_unsigned,
      output ready
   );
endinterface

interface rv32cd_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] pc_select;
   logic [4:0] src_a_reg;
   logic [4:0] src_b_reg;
   logic       alu_a_sel;
   logic       alu_b_sel;
   logic [3:0] alu_op;
   logic       mem_write;
   logic [1:0] mem_data_sel;
   logic [2:0] mem_format;
   logic       reg_write;
   logic [4:0] write_reg;
   logic       illegal;

   modport source (
      output valid, pc_select, src_a_reg, src_b_reg, alu_a_sel, alu_b_sel, alu_op,
             mem_write, mem_data_sel, mem_format, reg_write, write_reg, illegal,
      input  ready
   );
   modport sink (
      input  valid, pc_select, src_a_reg, src_b_reg, alu_a_sel, alu_b_sel, alu_op,
             mem_write, mem_data_sel, mem_format, reg_write, write_reg, illegal,
      output ready
   );
endinterface

/* rtl/rv32cd_decoder.sv */
// Next control word and illegal flag from one command and the current word.
module rv32cd_decoder (
   input  rv32cd_pkg::req_word_type  cmd,
   input  rv32cd_pkg::ctrl_word_type cur_word,
   output rv32cd_pkg::ctrl_word_type nxt_word,
   output logic                      illegal
);

   logic flag;
   logic imm_alt;

   // Pick the comparator flag for the branch condition
   always_comb begin
      case (cmd.funct3)
         3'd0, 3'd1: flag = cmd.cmp_equal;
         3'd4, 3'd5: flag = cmd.cmp_less;
         default:    flag = cmd.cmp_less_unsigned;
      endcase
   end

   assign imm_alt = (cmd.funct3 == rv32cd_pkg::F3_SHR) && (cmd.imm_upper != 7'd0);

   // Update the fields that the command assigns, hold the rest
   always_comb begin
      nxt_word = cur_word;
      illegal  = 1'b0;
      if (cmd.command == rv32cd_pkg::CMD_BRANCH) begin
         if (cmd.is_branch) begin
            if (cmd.funct3 == 3'd2 || cmd.funct3 == 3'd3) begin
               illegal = 1'b1;
            end else begin
               nxt_word.pc_select = {1'b0, flag ^ cmd.funct3[0]};
            end
         end
      end else begin
         nxt_word.pc_select = rv32cd_pkg::PC_SEQ;
         unique case (cmd.opcode)
            rv32cd_pkg::OPC_REG: begin
               nxt_word.src_a_reg    = cmd.src1_index;
               nxt_word.src_b_reg    = cmd.src2_index;
               nxt_word.alu_a_sel    = rv32cd_pkg::SEL_A_REG;
               nxt_word.alu_b_sel    = rv32cd_pkg::SEL_B_REG;
               nxt_word.alu_op       = rv32cd_pkg::alu_op_for(cmd.funct3,
                                                              cmd.funct7 != 7'd0);
               nxt_word.mem_write    = 1'b0;
               nxt_word.mem_data_sel = rv32cd_pkg::WB_ALU;
               nxt_word.reg_write    = 1'b1;
               nxt_word.write_reg    = cmd.dest_index;
            end
            rv32cd_pkg::OPC_IMM: begin
               nxt_word.src_a_reg    = cmd.src1_index;
               nxt_word.alu_a_sel    = rv32cd_pkg::SEL_A_REG;
               nxt_word.alu_b_sel    = rv32cd_pkg::SEL_B_IMM;
               nxt_word.alu_op       = rv32cd_pkg::alu_op_for(cmd.funct3, imm_alt);
               nxt_word.mem_write    = 1'b0;
               nxt_word.mem_data_sel = rv32cd_pkg::WB_ALU;
               nxt_word.reg_write    = 1'b1;
               nxt_word.write_reg    = cmd.dest_index;
            end
            rv32cd_pkg::OPC_LOAD: begin
               nxt_word.src_a_reg    = cmd.src1_index;
               nxt_word.alu_a_sel    = rv32cd_pkg::SEL_A_REG;
               nxt_word.alu_b_sel    = rv32cd_pkg::SEL_B_IMM;
               nxt_word.alu_op       = rv32cd_pkg::ALU_ADD;
               nxt_word.mem_write    = 1'b0;
               nxt_word.mem_data_sel = rv32cd_pkg::WB_MEM;
               if (cmd.funct3 == 3'd3 || cmd.funct3 >= 3'd6) begin
                  illegal = 1'b1;
               end else begin
                  nxt_word.mem_format = cmd.funct3;
                  nxt_word.reg_write  = 1'b1;
                  nxt_word.write_reg  = cmd.dest_index;
               end
            end
            rv32cd_pkg::OPC_STORE: begin
               nxt_word.src_a_reg = cmd.src1_index;
               nxt_word.src_b_reg = cmd.src2_index;
               nxt_word.alu_a_sel = rv32cd_pkg::SEL_A_REG;
               nxt_word.alu_b_sel = rv32cd_pkg::SEL_B_IMM;
               nxt_word.alu_op    = rv32cd_pkg::ALU_ADD;
               nxt_word.mem_write = 1'b1;
               if (cmd.funct3 >= 3'd3) begin
                  illegal = 1'b1;
               end else begin
                  // keep the unsigned bit, set the size
                  nxt_word.mem_format = {cur_word.mem_format[2], cmd.funct3[1:0]};
                  nxt_word.reg_write  = 1'b0;
               end
            end
            rv32cd_pkg::OPC_BRANCH: begin
               nxt_word.src_a_reg = cmd.src1_index;
               nxt_word.src_b_reg = cmd.src2_index;
               nxt_word.alu_a_sel = rv32cd_pkg::SEL_A_REG;
               nxt_word.alu_b_sel = rv32cd_pkg::SEL_B_REG;
               nxt_word.mem_write = 1'b0;
               nxt_word.reg_write = 1'b0;
               if (cmd.funct3 == 3'd2 || cmd.funct3 == 3'd3) begin
                  illegal = 1'b1;
               end else if (cmd.funct3 < 3'd2) begin
                  nxt_word.alu_op = rv32cd_pkg::ALU_SUB;
               end else if (cmd.funct3 < 3'd6) begin
                  nxt_word.alu_op = rv32cd_pkg::ALU_SLT;
               end else begin
                  nxt_word.alu_op = rv32cd_pkg::ALU_SLTU;
               end
            end
            rv32cd_pkg::OPC_JAL: begin
               nxt_word.pc_select    = rv32cd_pkg::PC_JUMP;
               nxt_word.mem_data_sel = rv32cd_pkg::WB_RET;
               nxt_word.mem_write    = 1'b0;
               nxt_word.reg_write    = 1'b1;
               nxt_word.write_reg    = cmd.dest_index;
            end
            rv32cd_pkg::OPC_JALR: begin
               nxt_word.pc_select    = rv32cd_pkg::PC_REG;
               nxt_word.src_a_reg    = cmd.src1_index;
               nxt_word.alu_a_sel    = rv32cd_pkg::SEL_A_REG;
               nxt_word.alu_b_sel    = rv32cd_pkg::SEL_B_IMM;
               nxt_word.alu_op       = rv32cd_pkg::ALU_ADD;
               nxt_word.mem_write    = 1'b0;
               nxt_word.mem_data_sel = rv32cd_pkg::WB_RET;
               nxt_word.reg_write    = 1'b1;
               nxt_word.write_reg    = cmd.dest_index;
            end
            rv32cd_pkg::OPC_LUI: begin
               nxt_word.src_a_reg    = 5'd0;
               nxt_word.alu_a_sel    = rv32cd_pkg::SEL_A_REG;
               nxt_word.alu_b_sel    = rv32cd_pkg::SEL_B_IMM;
               nxt_word.alu_op       = rv32cd_pkg::ALU_ADD;
               nxt_word.mem_write    = 1'b0;
               nxt_word.mem_data_sel = rv32cd_pkg::WB_ALU;
               nxt_word.reg_write    = 1'b1;
               nxt_word.write_reg    = cmd.dest_index;
            end
            rv32cd_pkg::OPC_AUIPC: begin
               nxt_word.alu_a_sel    = rv32cd_pkg::SEL_A_PC;
               nxt_word.alu_b_sel    = rv32cd_pkg::SEL_B_IMM;
               nxt_word.alu_op       = rv32cd_pkg::ALU_ADD;
               nxt_word.mem_write    = 1'b0;
               nxt_word.mem_data_sel = rv32cd_pkg::WB_ALU;
               nxt_word.reg_write    = 1'b1;
               nxt_word.write_reg    = cmd.dest_index;
            end
            rv32cd_pkg::OPC_SYSTEM: begin
               nxt_word.src_a_reg    = 5'd0;
               nxt_word.src_b_reg    = 5'd0;
               nxt_word.alu_a_sel    = rv32cd_pkg::SEL_A_REG;
               nxt_word.alu_b_sel    = rv32cd_pkg::SEL_B_REG;
               nxt_word.alu_op       = rv32cd_pkg::ALU_ADD;
               nxt_word.mem_write    = 1'b0;
               nxt_word.mem_data_sel = rv32cd_pkg::WB_ALU;
               nxt_word.reg_write    = 1'b0;
               nxt_word.write_reg    = 5'd0;
            end
            default: begin
               illegal = 1'b1;
            end
         endcase
      end
   end

endmodule

/* rtl/rv32i_control_decode.sv */
// RV32I control decode top: request register, decoder, control word register.
// A request word passes through the request register, then the control word register, which raises its response.
// Throughput: one word per cycle while the response side is ready; the request register is
// refilled as the control word register advances, so both sides stream without bubbles.
// Synchronous active-high reset clears the control word to zero and empties both stages.
`include "assert_macros.svh"

module rv32i_control_decode (
   input logic               clock,
   input logic               reset,
   rv32cd_req_if.sink        req_chan,
   rv32cd_rsp_if.source      rsp_chan
);

   rv32cd_pkg::req_word_type  req_ff;
   rv32cd_pkg::req_word_type  req_in;
   logic                      req_valid_ff;
   rv32cd_pkg::ctrl_word_type word_ff;
   rv32cd_pkg::ctrl_word_type word_in;
   logic                      illegal_ff;
   logic                      illegal_in;
   logic                      rsp_valid_ff;
   logic                      advance;
   logic                      req_take;

   // Move a word to the response stage when that stage is free or draining
   assign advance  = req_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_take = req_chan.valid && req_chan.ready;
   assign req_chan.ready = !req_valid_ff || advance;

   // Gather the request payload
   always_comb begin
      req_in.command           = req_chan.command;
      req_in.opcode            = req_chan.opcode;
      req_in.funct3            = req_chan.funct3;
      req_in.funct7            = req_chan.funct7;
      req_in.imm_upper         = req_chan.imm_upper;
      req_in.src1_index        = req_chan.src1_index;
      req_in.src2_index        = req_chan.src2_index;
      req_in.dest_index        = req_chan.dest_index;
      req_in.is_branch         = req_chan.is_branch;
      req_in.cmp_equal         = req_chan.cmp_equal;
      req_in.cmp_less          = req_chan.cmp_less;
      req_in.cmp_less_unsigned = req_chan.cmp_less_unsigned;
   end

   // Request stage
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_take) begin
         req_valid_ff <= 1'b1;
      end else if (advance) begin
         req_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         req_ff <= req_in;
      end
   end

   rv32cd_decoder u_decoder (
      .cmd      (req_ff),
      .cur_word (word_ff),
      .nxt_word (word_in),
      .illegal  (illegal_in)
   );

   // Control word: state and response register in one
   always_ff @(posedge clock) begin
      if (reset) begin
         word_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            word_ff <= word_in;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         illegal_ff <= illegal_in;
      end
   end

   // Drive the response channel
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.pc_select    = word_ff.pc_select;
   assign rsp_chan.src_a_reg    = word_ff.src_a_reg;
   assign rsp_chan.src_b_reg    = word_ff.src_b_reg;
   assign rsp_chan.alu_a_sel    = word_ff.alu_a_sel;
   assign rsp_chan.alu_b_sel    = word_ff.alu_b_sel;
   assign rsp_chan.alu_op       = word_ff.alu_op;
   assign rsp_chan.mem_write    = word_ff.mem_write;
   assign rsp_chan.mem_data_sel = word_ff.mem_data_sel;
   assign rsp_chan.mem_format   = word_ff.mem_format;
   assign rsp_chan.reg_write    = word_ff.reg_write;
   assign rsp_chan.write_reg    = word_ff.write_reg;
   assign rsp_chan.illegal      = illegal_ff;

   // Checks
   `ASSERT_NEXT(a_advance_shows, clock, reset, advance, rsp_valid_ff)
   `ASSERT_NEXT(a_stall_holds_word, clock, reset, rsp_valid_ff && !rsp_chan.ready,
                $stable(word_ff))
   `ASSERT_NEXT(a_branch_only_pc, clock, reset,
                advance && req_ff.command == rv32cd_pkg::CMD_BRANCH,
                word_ff[rv32cd_pkg::CTRL_LOW_BITS-1:0] ==
                $past(word_ff[rv32cd_pkg::CTRL_LOW_BITS-1:0]))
   `ASSERT_SAME(a_pc_sel_code, clock, reset, rsp_valid_ff, word_ff.pc_select != 2'd3)

endmodule

/* tb/rv32i_control_decode_checker.sv */
// Checker for the control decode block: predicts each control word and compares responses.
`timescale 1ns / 100ps

module rv32i_control_decode_checker
   import rv32cd_pkg::*;
(
   input  logic   clock,
   input  logic   reset,
   rv32cd_req_if  req_mon,
   rv32cd_rsp_if  rsp_mon,
   output int     mismatch_count,
   output int     words_pending
);

   typedef struct packed {
      ctrl_word_type word;
      logic          illegal;
   } decoded_word_type;

   ctrl_word_type     control_state;
   decoded_word_type  expected_words[$];
   int                mismatches;

   // ALU operation selected by funct3, with the sub / arithmetic-shift variant
   function automatic logic [3:0] op_from_funct3(input logic [2:0] f3, input logic alt);
      logic [3:0] op;
      case (f3)
         3'd0:    op = alt ? ALU_SUB : ALU_ADD;
         3'd1:    op = ALU_SLL;
         3'd2:    op = ALU_SLT;
         3'd3:    op = ALU_SLTU;
         3'd4:    op = ALU_XOR;
         3'd5:    op = alt ? ALU_SRA : ALU_SRL;
         3'd6:    op = ALU_OR;
         default: op = ALU_AND;
      endcase
      return op;
   endfunction

   // Resolve a branch from the comparator flags; returns the illegal flag
   function automatic logic resolve_branch_word(input req_word_type w);
      logic taken;
      taken = 1'b0;
      if (!w.is_branch)
         return 1'b0;
      case (w.funct3)
         3'd0, 3'd1: taken = w.cmp_equal;
         3'd4, 3'd5: taken = w.cmp_less;
         3'd6, 3'd7: taken = w.cmp_less_unsigned;
         default:    return 1'b1;
      endcase
      // odd funct3 codes take the inverted condition
      control_state.pc_select = (taken ^ w.funct3[0]) ? PC_JUMP : PC_SEQ;
      return 1'b0;
   endfunction

   // Update the kept control word from one instruction; returns the illegal flag
   function automatic logic decode_word(input req_word_type w);
      logic alt;
      control_state.pc_select = PC_SEQ;
      case (w.opcode)
         OPC_REG, OPC_IMM: begin
            control_state.src_a_reg = w.src1_index;
            if (w.opcode == OPC_REG)
               control_state.src_b_reg = w.src2_index;
            control_state.alu_a_sel = SEL_A_REG;
            control_state.alu_b_sel = (w.opcode == OPC_IMM) ? SEL_B_IMM : SEL_B_REG;
            if (w.opcode == OPC_REG)
               alt = (w.funct7 != '0);
            else
               alt = (w.funct3 == F3_SHR) && (w.imm_upper != '0);
            control_state.alu_op = op_from_funct3(w.funct3, alt);
            control_state.mem_write = 1'b0;
            control_state.mem_data_sel = WB_ALU;
            control_state.reg_write = 1'b1;
            control_state.write_reg = w.dest_index;
         end
         OPC_LOAD: begin
            control_state.src_a_reg = w.src1_index;
            control_state.alu_a_sel = SEL_A_REG;
            control_state.alu_b_sel = SEL_B_IMM;
            control_state.alu_op = ALU_ADD;
            control_state.mem_write = 1'b0;
            control_state.mem_data_sel = WB_MEM;
            // no word load wider than 32 bits, no unsigned word load
            if (w.funct3 == 3'd3 || w.funct3 >= 3'd6)
               return 1'b1;
            control_state.mem_format = w.funct3;
            control_state.reg_write = 1'b1;
            control_state.write_reg = w.dest_index;
         end
         OPC_STORE: begin
            control_state.src_a_reg = w.src1_index;
            control_state.src_b_reg = w.src2_index;
            control_state.alu_a_sel = SEL_A_REG;
            control_state.alu_b_sel = SEL_B_IMM;
            control_state.alu_op = ALU_ADD;
            control_state.mem_write = 1'b1;
            if (w.funct3 >= 3'd3)
               return 1'b1;
            // size only; the unsigned bit is left from the last load
            control_state.mem_format[1:0] = w.funct3[1:0];
            control_state.reg_write = 1'b0;
         end
         OPC_BRANCH: begin
            control_state.src_a_reg = w.src1_index;
            control_state.src_b_reg = w.src2_index;
            control_state.alu_a_sel = SEL_A_REG;
            control_state.alu_b_sel = SEL_B_REG;
            control_state.mem_write = 1'b0;
            control_state.reg_write = 1'b0;
            if (w.funct3 == 3'd2 || w.funct3 == 3'd3)
               return 1'b1;
            if (w.funct3 < 3'd2)
               control_state.alu_op = ALU_SUB;
            else if (w.funct3 < 3'd6)
               control_state.alu_op = ALU_SLT;
            else
               control_state.alu_op = ALU_SLTU;
         end
         OPC_JAL: begin
            control_state.pc_select = PC_JUMP;
            control_state.mem_data_sel = WB_RET;
            control_state.mem_write = 1'b0;
            control_state.reg_write = 1'b1;
            control_state.write_reg = w.dest_index;
         end
         OPC_JALR, OPC_LUI, OPC_AUIPC: begin
            if (w.opcode == OPC_JALR) begin
               control_state.pc_select = PC_REG;
               control_state.src_a_reg = w.src1_index;
            end
            if (w.opcode == OPC_LUI)
               control_state.src_a_reg = '0;
            control_state.alu_a_sel = (w.opcode == OPC_AUIPC) ? SEL_A_PC : SEL_A_REG;
            control_state.alu_b_sel = SEL_B_IMM;
            control_state.alu_op = ALU_ADD;
            control_state.mem_write = 1'b0;
            control_state.mem_data_sel = (w.opcode == OPC_JALR) ? WB_RET : WB_ALU;
            control_state.reg_write = 1'b1;
            control_state.write_reg = w.dest_index;
         end
         OPC_SYSTEM: begin
            control_state.src_a_reg = '0;
            control_state.src_b_reg = '0;
            control_state.alu_a_sel = SEL_A_REG;
            control_state.alu_b_sel = SEL_B_REG;
            control_state.alu_op = ALU_ADD;
            control_state.mem_write = 1'b0;
            control_state.mem_data_sel = WB_ALU;
            control_state.reg_write = 1'b0;
            control_state.write_reg = '0;
         end
         default: return 1'b1;
      endcase
      return 1'b0;
   endfunction

   task automatic check_field(input string field, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
      end
   endtask

   // Compare accepted responses first, then predict the accepted request
   always @(posedge clock) begin
      decoded_word_type want;
      if (reset) begin
         control_state = '0;
         expected_words.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_words.size() == 0) begin
               mismatches++;
               $display("%0t: response word with none expected, expected nothing actual %h",
                        $time, {rsp_mon.pc_select, rsp_mon.src_a_reg, rsp_mon.illegal});
            end else begin
               want = expected_words.pop_front();
               check_field("pc_select", want.word.pc_select, rsp_mon.pc_select);
               check_field("src_a_reg", want.word.src_a_reg, rsp_mon.src_a_reg);
               check_field("src_b_reg", want.word.src_b_reg, rsp_mon.src_b_reg);
               check_field("alu_a_sel", want.word.alu_a_sel, rsp_mon.alu_a_sel);
               check_field("alu_b_sel", want.word.alu_b_sel, rsp_mon.alu_b_sel);
               check_field("alu_op", want.word.alu_op, rsp_mon.alu_op);
               check_field("mem_write", want.word.mem_write, rsp_mon.mem_write);
               check_field("mem_data_sel", want.word.mem_data_sel, rsp_mon.mem_data_sel);
               check_field("mem_format", want.word.mem_format, rsp_mon.mem_format);
               check_field("reg_write", want.word.reg_write, rsp_mon.reg_write);
               check_field("write_reg", want.word.write_reg, rsp_mon.write_reg);
               check_field("illegal", want.illegal, rsp_mon.illegal);
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            req_word_type w;
            w = '{command: req_mon.command, opcode: req_mon.opcode,
                  funct3: req_mon.funct3, funct7: req_mon.funct7,
                  imm_upper: req_mon.imm_upper, src1_index: req_mon.src1_index,
                  src2_index: req_mon.src2_index, dest_index: req_mon.dest_index,
                  is_branch: req_mon.is_branch, cmp_equal: req_mon.cmp_equal,
                  cmp_less: req_mon.cmp_less,
                  cmp_less_unsigned: req_mon.cmp_less_unsigned};
            if (w.command == CMD_BRANCH)
               want.illegal = resolve_branch_word(w);
            else
               want.illegal = decode_word(w);
            want.word = control_state;
            expected_words.push_back(want);
         end
      end
      words_pending <= expected_words.size();
      mismatch_count <= mismatches;
   end

   initial begin
      mismatches = 0;
      control_state = '0;
      words_pending = 0;
      mismatch_count = 0;
   end

endmodule

/* tb/rv32i_control_decode_tb.sv */
// Top of the control decode testbench: clock, reset, stimulus, stalls and verdict.
`timescale 1ns / 100ps

module rv32i_control_decode_tb;
   import rv32cd_pkg::*;

   localparam int PHASE_WORDS = 600;
   localparam int LONG_STALL  = 300;
   localparam int CYCLE_LIMIT = 400000;

   // funct3 codes used by the directed words
   localparam logic [2:0] F3_EQ  = 3'd0;
   localparam logic [2:0] F3_NE  = 3'd1;
   localparam logic [2:0] F3_BAD = 3'd3;
   localparam logic [2:0] F3_GE  = 3'd5;
   localparam logic [2:0] F3_GEU = 3'd7;
   localparam logic [2:0] F3_HALF_UNSIGNED = 3'd5;
   localparam logic [2:0] F3_BYTE_UNSIGNED = 3'd4;
   localparam logic [2:0] F3_WORD = 3'd2;
   localparam logic [2:0] F3_LAST = 3'd7;
   localparam logic [2:0] F3_SLTU = 3'd6;

   logic clock;
   logic reset;
   int   send_idle_pct;
   int   recv_idle_pct;
   logic long_stall_due;
   int   words_sent;
   int   mismatch_count;
   int   words_pending;

   rv32cd_req_if req_chan();
   rv32cd_rsp_if rsp_chan();

   rv32i_control_decode dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   rv32i_control_decode_checker checker_inst (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_chan),
      .rsp_mon        (rsp_chan),
      .mismatch_count (mismatch_count),
      .words_pending  (words_pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hold the run to a bounded number of cycles
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("rv32i_control_decode regression: fail");
      $finish;
   end

   // Response side: random ready, with one long hold-off on request
   initial begin
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (long_stall_due) begin
            long_stall_due = 1'b0;
            rsp_chan.ready <= 1'b0;
            repeat (LONG_STALL) @(posedge clock);
         end
         rsp_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   function automatic req_word_type make_word(
      input logic cmd, input logic [6:0] opc, input logic [2:0] f3,
      input logic [6:0] f7, input logic [6:0] immu, input logic [4:0] rs1,
      input logic [4:0] rs2, input logic [4:0] rd, input logic br,
      input logic eq, input logic lt, input logic ltu);
      req_word_type w;
      w = '{command: cmd, opcode: opc, funct3: f3, funct7: f7, imm_upper: immu,
            src1_index: rs1, src2_index: rs2, dest_index: rd, is_branch: br,
            cmp_equal: eq, cmp_less: lt, cmp_less_unsigned: ltu};
      return w;
   endfunction

   // Mostly known opcodes with random content; some raw opcodes as noise
   function automatic req_word_type random_word();
      req_word_type w;
      logic [63:0]  bits;
      bits = {$urandom, $urandom};
      w = bits[$bits(req_word_type)-1:0];
      w.command = ($urandom_range(99) < 30) ? CMD_BRANCH : CMD_DECODE;
      if ($urandom_range(99) < 88) begin
         case ($urandom_range(9))
            0: w.opcode = OPC_REG;
            1: w.opcode = OPC_IMM;
            2: w.opcode = OPC_LOAD;
            3: w.opcode = OPC_STORE;
            4: w.opcode = OPC_BRANCH;
            5: w.opcode = OPC_JAL;
            6: w.opcode = OPC_JALR;
            7: w.opcode = OPC_LUI;
            8: w.opcode = OPC_AUIPC;
            default: w.opcode = OPC_SYSTEM;
         endcase
      end
      if ($urandom_range(3) == 0)
         w.funct7 = '0;
      if ($urandom_range(3) == 0)
         w.imm_upper = '0;
      w.is_branch = ($urandom_range(99) < 85);
      return w;
   endfunction

   // Offer one word, idling at random first, and hold it until accepted
   task automatic send_word(input req_word_type w);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid             <= 1'b1;
      req_chan.command           <= w.command;
      req_chan.opcode            <= w.opcode;
      req_chan.funct3            <= w.funct3;
      req_chan.funct7            <= w.funct7;
      req_chan.imm_upper         <= w.imm_upper;
      req_chan.src1_index        <= w.src1_index;
      req_chan.src2_index        <= w.src2_index;
      req_chan.dest_index        <= w.dest_index;
      req_chan.is_branch         <= w.is_branch;
      req_chan.cmp_equal         <= w.cmp_equal;
      req_chan.cmp_less          <= w.cmp_less;
      req_chan.cmp_less_unsigned <= w.cmp_less_unsigned;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      words_sent++;
   endtask

   initial begin
      reset          <= 1'b1;
      req_chan.valid <= 1'b0;
      req_chan.command           <= CMD_DECODE;
      req_chan.opcode            <= '0;
      req_chan.funct3            <= '0;
      req_chan.funct7            <= '0;
      req_chan.imm_upper         <= '0;
      req_chan.src1_index        <= '0;
      req_chan.src2_index        <= '0;
      req_chan.dest_index        <= '0;
      req_chan.is_branch         <= 1'b0;
      req_chan.cmp_equal         <= 1'b0;
      req_chan.cmp_less          <= 1'b0;
      req_chan.cmp_less_unsigned <= 1'b0;
      send_idle_pct  = 13;
      recv_idle_pct  = 85;
      long_stall_due = 1'b0;
      words_sent     = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: every opcode, the alternate ALU encodings, illegal funct3 and an illegal opcode
      send_word(make_word(CMD_DECODE, OPC_REG, F3_ADD_SUB, 7'h00, 7'h00, 5'd31, 5'd0, 5'd31,
                          1'b0, 1'b0, 1'b0, 1'b0));
      send_word(make_word(CMD_DECODE, OPC_REG, F3_ADD_SUB, 7'h7F, 7'h00, 5'd0, 5'd31, 5'd0,
                          1'b0, 1'b0, 1'b0, 1'b0));
      send_word(make_word(CMD_DECODE, OPC_REG, F3_SHR, 7'h20, 7'h00, 5'd5, 5'd6, 5'd7,
                          1'b0, 1'b0, 1'b0, 1'b0));
      send_word(make_word(CMD_DECODE, OPC_REG, F3_LAST, 7'h00, 7'h7F, 5'd1, 5'd2, 5'd3,
                          1'b0, 1'b0, 1'b0, 1'b0));
      send_word(make_word(CMD_DECODE, OPC_IMM, F3_SHR, 7'h7F, 7'h00, 5'd9, 5'd10, 5'd11,
                          1'b0, 1'b0, 1'b0, 1'b0));
      send_word(make_word(CMD_DECODE, OPC_IMM, F3_SHR, 7'h00, 7'h7F, 5'd12, 5'd13, 5'd14,
                          1'b0, 1'b0, 1'b0, 1'b0));
      send_word(make_word(CMD_DECODE, OPC_IMM, F3_ADD_SUB, 7'h7F, 7'h40, 5'd15, 5'd16, 5'd17,
                          1'b0, 1'b0, 1'b0, 1'b0));
      send_word(make_word(CMD_DECODE, OPC_LOAD, F3_BYTE_UNSIGNED, 7'h00, 7'h00, 5'd18, 5'd19,
                          5'd20, 1'b0, 1'b0, 1'b0, 1'b0));
      send_word(make_word(CMD_DECODE, OPC_STORE, F3_WORD, 7'h00, 7'h00, 5'd21, 5'd22, 5'd23,
                          1'b0, 1'b0, 1'b0, 1'b0));
      send_word(make_word(CMD_DECODE, OPC_LOAD, F3_BAD, 7'h00, 7'h00, 5'd24, 5'd25, 5'd26,
                          1'b0, 1'b0, 1'b0, 1'b0));
      send_word(make_word(CMD_DECODE, OPC_LOAD, F3_LAST, 7'h00, 7'h00, 5'd27, 5'd28, 5'd29,
                          1'b0, 1'b0, 1'b0, 1'b0));
      send_word(make_word(CMD_DECODE, OPC_LOAD, F3_HALF_UNSIGNED, 7'h00, 7'h00, 5'd4, 5'd8,
                          5'd30, 1'b0, 1'b0, 1'b0, 1'b0));
      send_word(make_word(CMD_DECODE, OPC_STORE, F3_LAST, 7'h00, 7'h00, 5'd30, 5'd29, 5'd28,
                          1'b0, 1'b0, 1'b0, 1'b0));
      send_word(make_word(CMD_DECODE, OPC_BRANCH, F3_SLTU, 7'h00, 7'h00, 5'd3, 5'd4, 5'd5,
                          1'b0, 1'b0, 1'b0, 1'b0));
      send_word(make_word(CMD_DECODE, OPC_BRANCH, F3_WORD, 7'h00, 7'h00, 5'd6, 5'd7, 5'd8,
                          1'b0, 1'b0, 1'b0, 1'b0));
      // Branch resolution: each flag, both polarities, a bad funct3 and a non-branch
      send_word(make_word(CMD_BRANCH, OPC_BRANCH, F3_EQ, 7'h00, 7'h00, 5'd0, 5'd0, 5'd0,
                          1'b1, 1'b1, 1'b0, 1'b0));
      send_word(make_word(CMD_BRANCH, OPC_BRANCH, F3_NE, 7'h00, 7'h00, 5'd0, 5'd0, 5'd0,
                          1'b1, 1'b1, 1'b1, 1'b1));
      send_word(make_word(CMD_BRANCH, OPC_BRANCH, F3_GE, 7'h00, 7'h00, 5'd0, 5'd0, 5'd0,
                          1'b1, 1'b1, 1'b0, 1'b1));
      send_word(make_word(CMD_BRANCH, OPC_BRANCH, F3_GEU, 7'h00, 7'h00, 5'd0, 5'd0, 5'd0,
                          1'b1, 1'b0, 1'b0, 1'b1));
      send_word(make_word(CMD_BRANCH, OPC_BRANCH, F3_BAD, 7'h00, 7'h00, 5'd0, 5'd0, 5'd0,
                          1'b1, 1'b1, 1'b1, 1'b1));
      send_word(make_word(CMD_BRANCH, OPC_BRANCH, F3_EQ, 7'h00, 7'h00, 5'd0, 5'd0, 5'd0,
                          1'b0, 1'b1, 1'b1, 1'b1));
      send_word(make_word(CMD_DECODE, OPC_JAL, F3_EQ, 7'h00, 7'h00, 5'd1, 5'd1, 5'd31,
                          1'b0, 1'b0, 1'b0, 1'b0));
      send_word(make_word(CMD_DECODE, OPC_JALR, F3_LAST, 7'h00, 7'h00, 5'd31, 5'd1, 5'd2,
                          1'b0, 1'b0, 1'b0, 1'b0));
      send_word(make_word(CMD_DECODE, OPC_LUI, F3_EQ, 7'h00, 7'h00, 5'd7, 5'd7, 5'd9,
                          1'b0, 1'b0, 1'b0, 1'b0));
      send_word(make_word(CMD_DECODE, OPC_AUIPC, F3_EQ, 7'h00, 7'h00, 5'd7, 5'd7, 5'd10,
                          1'b0, 1'b0, 1'b0, 1'b0));
      send_word(make_word(CMD_DECODE, OPC_SYSTEM, F3_EQ, 7'h00, 7'h00, 5'd31, 5'd31, 5'd31,
                          1'b0, 1'b0, 1'b0, 1'b0));
      send_word(make_word(CMD_DECODE, 7'h7F, F3_EQ, 7'h00, 7'h00, 5'd2, 5'd2, 5'd2,
                          1'b0, 1'b0, 1'b0, 1'b0));

      // Random words in three stall mixes; the last one opens with a long hold-off
      repeat (PHASE_WORDS) send_word(random_word());
      send_idle_pct = 85;
      recv_idle_pct = 13;
      repeat (PHASE_WORDS) send_word(random_word());
      send_idle_pct  = 0;
      recv_idle_pct  = 0;
      long_stall_due = 1'b1;
      repeat (PHASE_WORDS) send_word(random_word());
      req_chan.valid <= 1'b0;

      // Drain the pipeline, then keep watching for stray words
      @(posedge clock);
      while (words_pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("Streamed %0d decode and branch words through sender-heavy, receiver-heavy",
               words_sent);
      $display("and back-to-back traffic, including a long response hold-off.");
      if (mismatch_count == 0)
         $display("rv32i_control_decode regression: pass");
      else
         $display("rv32i_control_decode regression: fail");
      $finish;
   end

endmodule
